// ===== hdl/ptt_pkg.sv =====
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_TOP_K       = 10;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [15:0] MIN_FRAME_LEN  = 16'd14;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [11:0] WINDOW_RESET   = 12'd2;

   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [31:0] source_addr;
      logic [31:0] time_sec;
      logic [19:0] time_usec;
   } req_type;

   typedef struct packed {
      logic [5:0]  rank;
      logic [31:0] talker_addr;
      logic [31:0] talker_count;
      logic [31:0] window_packets;
      logic [16:0] distinct_sources;
      logic [31:0] window_end_sec;
      logic        table_overflow;
      logic        entry_valid;
      logic        last;
   } rsp_type;

   // One classified packet handed from the front end to the table engine.
   typedef struct packed {
      logic        qualify;
      logic        close;
      logic [31:0] source_addr;
      logic [31:0] end_sec;
   } job_type;

endpackage

// ===== hdl/ptt_front.sv =====
`timescale 1ns / 1ps

module ptt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [11:0]      csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptt_pkg::req_type req_payload,
   input  logic             queue_full,
   output logic             job_push,
   output ptt_pkg::job_type job_data
);
   import ptt_pkg::*;

   logic [11:0] window_seconds_ff;
   logic        window_open_ff;
   logic [31:0] start_sec_ff;
   logic [19:0] start_usec_ff;

   logic [31:0] start_sec_in;
   logic [19:0] start_usec_in;
   logic [33:0] elapsed;
   logic        close;
   logic        qualify;

   assign req_stall = queue_full;
   assign job_push  = req_valid && !queue_full;

   // A packet that finds the window closed opens it with its own timestamp.
   assign start_sec_in  = window_open_ff ? start_sec_ff  : req_payload.time_sec;
   assign start_usec_in = window_open_ff ? start_usec_ff : req_payload.time_usec;

   assign elapsed = {2'b00, req_payload.time_sec} - {2'b00, start_sec_in}
                    - 34'(req_payload.time_usec < start_usec_in);
   assign close   = !elapsed[33] && (elapsed >= {22'd0, window_seconds_ff});

   assign qualify = (req_payload.frame_length > MIN_FRAME_LEN)
                    && (req_payload.ether_type == ETHERTYPE_IPV4)
                    && ((req_payload.ip_protocol == PROTO_TCP)
                        || (req_payload.ip_protocol == PROTO_UDP));

   always_comb begin
      job_data.qualify     = qualify;
      job_data.close       = close;
      job_data.source_addr = req_payload.source_addr;
      job_data.end_sec     = req_payload.time_sec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_seconds_ff <= WINDOW_RESET;
         window_open_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            window_seconds_ff <= csr_write_data;
         end
         if (job_push) begin
            window_open_ff <= !close;
         end
      end
      if (job_push) begin
         start_sec_ff  <= start_sec_in;
         start_usec_ff <= start_usec_in;
      end
   end

endmodule

// ===== hdl/ptt_fifo.sv =====
`timescale 1ns / 1ps

module ptt_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptt_pkg::job_type push_data,
   input  logic             pop,
   output ptt_pkg::job_type pop_data,
   output logic             full,
   output logic             empty
);
   import ptt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   fill_ff;

   assign full     = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop && !empty) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if ((push && !full) && !(pop && !empty)) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (!(push && !full) && (pop && !empty)) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/ptt_back.sv =====
`timescale 1ns / 1ps

module ptt_back #(
   parameter int TABLE_DEPTH = ptt_pkg::DEF_TABLE_DEPTH,
   parameter int TOP_K       = ptt_pkg::DEF_TOP_K
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_avail,
   input  ptt_pkg::job_type job_data,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptt_pkg::rsp_type rsp_payload
);
   import ptt_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = IDX_W + 1;
   localparam int PASS_W = $clog2(TOP_K + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SEL,
      ST_PEND,
      ST_FINAL
   } state_type;

   state_type        state_ff;
   job_type          job_ff;
   logic [CNT_W-1:0] used_ff;
   logic [31:0]      packets_ff;
   logic             overflow_ff;

   logic [CNT_W-1:0] scan_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   logic [PASS_W-1:0] pass_ff;
   logic              found_ff;
   logic [31:0]       best_addr_ff;
   logic [31:0]       best_cnt_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              have_pend_ff;
   logic [31:0]       pend_addr_ff;
   logic [31:0]       pend_cnt_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [PASS_W-1:0] pend_rank_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [31:0] source_mem [TABLE_DEPTH];
   logic [31:0] count_mem  [TABLE_DEPTH];
   logic [31:0] rd_src_ff;
   logic [31:0] rd_cnt_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_src;
   logic [31:0]      wr_cnt;

   logic hit;
   logic scan_done;
   logic room;
   logic eligible;
   logic out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign job_pop     = (state_ff == ST_IDLE) && job_avail;

   assign hit       = chk_vld_ff && (rd_src_ff == job_ff.source_addr);
   assign scan_done = !chk_vld_ff && (scan_ff >= used_ff);
   assign room      = used_ff < CNT_W'(TABLE_DEPTH);

   // Ranking order is count descending, then table index ascending. An entry
   // may be picked in this pass only if it ranks below the previous pick.
   assign eligible = !have_pend_ff || (rd_cnt_ff < pend_cnt_ff)
                     || ((rd_cnt_ff == pend_cnt_ff) && (chk_idx_ff > pend_idx_ff));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chk_idx_ff;
      wr_src  = rd_src_ff;
      wr_cnt  = (rd_cnt_ff == 32'hFFFF_FFFF) ? rd_cnt_ff : rd_cnt_ff + 32'd1;
      if (state_ff == ST_LOOK) begin
         if (hit) begin
            wr_en = 1'b1;
         end else if (scan_done && room) begin
            wr_en   = 1'b1;
            wr_addr = used_ff[IDX_W-1:0];
            wr_src  = job_ff.source_addr;
            wr_cnt  = 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         source_mem[wr_addr] <= wr_src;
         count_mem[wr_addr]  <= wr_cnt;
      end
      rd_src_ff <= source_mem[scan_ff[IDX_W-1:0]];
      rd_cnt_ff <= count_mem[scan_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         packets_ff   <= '0;
         overflow_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         have_pend_ff <= 1'b0;
         pass_ff      <= '0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // Table read pipeline shared by lookup and selection passes.
         if (scan_ff < used_ff) begin
            scan_ff    <= scan_ff + 1'b1;
            chk_vld_ff <= 1'b1;
            chk_idx_ff <= scan_ff[IDX_W-1:0];
         end else begin
            chk_vld_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (job_avail) begin
                  job_ff     <= job_data;
                  scan_ff    <= '0;
                  chk_vld_ff <= 1'b0;
                  if (packets_ff != 32'hFFFF_FFFF) begin
                     packets_ff <= packets_ff + 32'd1;
                  end
                  pass_ff      <= '0;
                  found_ff     <= 1'b0;
                  have_pend_ff <= 1'b0;
                  if (job_data.qualify) begin
                     state_ff <= ST_LOOK;
                  end else if (job_data.close) begin
                     state_ff <= ST_SEL;
                  end
               end
            end
            ST_LOOK: begin
               if (hit || scan_done) begin
                  if (!hit) begin
                     if (room) begin
                        used_ff <= used_ff + 1'b1;
                     end else begin
                        overflow_ff <= 1'b1;
                     end
                  end
                  scan_ff    <= '0;
                  chk_vld_ff <= 1'b0;
                  state_ff   <= job_ff.close ? ST_SEL : ST_IDLE;
               end
            end
            ST_SEL: begin
               if (chk_vld_ff && eligible && (!found_ff || (rd_cnt_ff > best_cnt_ff))) begin
                  found_ff     <= 1'b1;
                  best_addr_ff <= rd_src_ff;
                  best_cnt_ff  <= rd_cnt_ff;
                  best_idx_ff  <= chk_idx_ff;
               end
               if (scan_done) begin
                  state_ff <= ST_PEND;
               end
            end
            ST_PEND: begin
               if (!found_ff) begin
                  state_ff <= ST_FINAL;
               end else if (!have_pend_ff || out_free) begin
                  if (have_pend_ff) begin
                     rsp_valid_ff           <= 1'b1;
                     rsp_ff.rank            <= 6'(pend_rank_ff);
                     rsp_ff.talker_addr     <= pend_addr_ff;
                     rsp_ff.talker_count    <= pend_cnt_ff;
                     rsp_ff.window_packets  <= packets_ff;
                     rsp_ff.distinct_sources <= 17'(used_ff);
                     rsp_ff.window_end_sec  <= job_ff.end_sec;
                     rsp_ff.table_overflow  <= overflow_ff;
                     rsp_ff.entry_valid     <= 1'b1;
                     rsp_ff.last            <= 1'b0;
                  end
                  have_pend_ff <= 1'b1;
                  pend_addr_ff <= best_addr_ff;
                  pend_cnt_ff  <= best_cnt_ff;
                  pend_idx_ff  <= best_idx_ff;
                  pend_rank_ff <= pass_ff;
                  found_ff     <= 1'b0;
                  if (pass_ff + 1'b1 < PASS_W'(TOP_K)) begin
                     pass_ff    <= pass_ff + 1'b1;
                     scan_ff    <= '0;
                     chk_vld_ff <= 1'b0;
                     state_ff   <= ST_SEL;
                  end else begin
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_FINAL: begin
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_ff.rank             <= have_pend_ff ? 6'(pend_rank_ff) : 6'd0;
                  rsp_ff.talker_addr      <= have_pend_ff ? pend_addr_ff : 32'd0;
                  rsp_ff.talker_count     <= have_pend_ff ? pend_cnt_ff : 32'd0;
                  rsp_ff.window_packets   <= packets_ff;
                  rsp_ff.distinct_sources <= 17'(used_ff);
                  rsp_ff.window_end_sec   <= job_ff.end_sec;
                  rsp_ff.table_overflow   <= overflow_ff;
                  rsp_ff.entry_valid      <= have_pend_ff;
                  rsp_ff.last             <= 1'b1;
                  used_ff     <= '0;
                  packets_ff  <= '0;
                  overflow_ff <= 1'b0;
                  scan_ff     <= '0;
                  chk_vld_ff  <= 1'b0;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/per_source_window_top_talkers_top.sv =====
`timescale 1ns / 1ps

// Windowed top-talker counter. Each req beat summarizes one packet; every
// packet counts toward the window total, and IPv4 TCP or UDP frames longer
// than 14 bytes are also counted per source address in a table of
// TABLE_DEPTH entries filled in order of first appearance. The window opens
// on the first packet and closes on the packet whose elapsed time (whole
// seconds with a microsecond borrow) reaches window_seconds; that packet is
// counted first. At close the block sends the TOP_K busiest sources on rsp in
// descending count order, ties going to the earlier source, with last set on
// the final beat, or a single empty marker beat when nothing was counted.
// A front end classifies packets and tracks window timing with no wait; a
// two-beat queue feeds the table engine, which holds one table read port.
// A packet that is not counted needs only the idle state in the engine; a
// counted packet is looked up by walking the table's sources one entry
// per cycle. A close adds up to TOP_K selection passes over the table
// (one more pass than there are sources when the table holds fewer than
// TOP_K), then a visit to the final state
// for the final beat. Ranked beats leave during the passes, and a stalled
// result beat holds the engine until it is taken. Table contents need no
// clearing pass: a fill count marks which entries hold data, so the next
// window starts immediately after a close.

module per_source_window_top_talkers_top #(
   parameter int TABLE_DEPTH = ptt_pkg::DEF_TABLE_DEPTH,
   parameter int TOP_K       = ptt_pkg::DEF_TOP_K
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [11:0]      csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptt_pkg::rsp_type rsp_payload
);
   import ptt_pkg::*;

   // Classified packets wait here so the front never blocks on table work
   // until the queue fills.
   logic    job_push;
   job_type job_in;
   logic    job_pop;
   job_type job_out;
   logic    queue_full;
   logic    queue_empty;

   ptt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .queue_full     (queue_full),
      .job_push       (job_push),
      .job_data       (job_in)
   );

   ptt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // The engine owns the table, the window counters and the result register.
   ptt_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TOP_K       (TOP_K)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_avail   (!queue_empty),
      .job_data    (job_out),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== verif/tb_per_source_window_top_talkers_top.sv =====
`timescale 1ns / 1ps

// Testbench for the windowed top-talker counter. Packets are sent one beat at a
// time on req while a local copy of the table and window state works out which
// ranked entries each window close must produce. Those predictions wait in a
// queue, and every beat that leaves on rsp is checked against the oldest one.

module tb_per_source_window_top_talkers_top;
   import ptt_pkg::*;

   localparam int DEPTH      = DEF_TABLE_DEPTH;
   localparam int RANKS      = DEF_TOP_K;
   // Packets still in flight after the last close: up to three lookups, each
   // walking a full table.
   localparam int DRAIN      = 4 * (DEPTH + 8) + 400;
   localparam int IDLE_LIMIT = 40000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_write_en = 1'b0;
   logic [11:0] csr_write_data = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   per_source_window_top_talkers_top u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

   always #10 clock = ~clock;

   // Shadow of the block's window state.
   logic [31:0] talker_addr_tab [DEPTH];
   logic [31:0] talker_count_tab[DEPTH];
   int          talkers_used;
   logic [31:0] window_pkts;
   bit          window_is_open;
   logic [31:0] open_sec;
   logic [19:0] open_usec;
   bit          table_full_seen;
   logic [11:0] window_len;

   rsp_type ranked_expect[$];
   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;
   int      mismatches = 0;
   int      beats_checked = 0;
   int      packets_sent = 0;
   int      closes_seen = 0;
   int      quiet_cycles = 0;

   // Clear everything that a window close or reset clears.
   task automatic reset_window();
      talkers_used    = 0;
      window_pkts     = '0;
      window_is_open  = 1'b0;
      open_sec        = '0;
      open_usec       = '0;
      table_full_seen = 1'b0;
   endtask

   // Rank the table, queue the resulting beats and start a fresh window.
   task automatic rank_talkers(input logic [31:0] end_sec);
      bit      taken[DEPTH];
      int      best;
      int      n;
      rsp_type r;
      n = 0;
      for (int i = 0; i < DEPTH; i++) taken[i] = 1'b0;
      for (int k = 0; k < RANKS; k++) begin
         best = -1;
         for (int i = 0; i < talkers_used; i++) begin
            if (!taken[i] && (best < 0 || talker_count_tab[i] > talker_count_tab[best]))
               best = i;
         end
         if (best < 0) break;
         taken[best] = 1'b1;
         r.rank             = 6'(k);
         r.talker_addr      = talker_addr_tab[best];
         r.talker_count     = talker_count_tab[best];
         r.window_packets   = window_pkts;
         r.distinct_sources = 17'(talkers_used);
         r.window_end_sec   = end_sec;
         r.table_overflow   = table_full_seen;
         r.entry_valid      = 1'b1;
         r.last             = 1'b0;
         ranked_expect.push_back(r);
         n++;
      end
      if (n == 0) begin
         // Nothing was counted: a single empty marker beat.
         r = '0;
         r.window_packets   = window_pkts;
         r.distinct_sources = 17'(talkers_used);
         r.window_end_sec   = end_sec;
         r.table_overflow   = table_full_seen;
         r.last             = 1'b1;
         ranked_expect.push_back(r);
      end else begin
         ranked_expect[$].last = 1'b1;
      end
      closes_seen++;
      reset_window();
   endtask

   // Apply one accepted packet to the shadow state.
   task automatic count_packet(input req_type p);
      longint elapsed;
      int     hit;
      if (!window_is_open) begin
         window_is_open = 1'b1;
         open_sec       = p.time_sec;
         open_usec      = p.time_usec;
      end
      if (p.frame_length > MIN_FRAME_LEN && p.ether_type == ETHERTYPE_IPV4 &&
          (p.ip_protocol == PROTO_TCP || p.ip_protocol == PROTO_UDP)) begin
         hit = -1;
         for (int i = 0; i < talkers_used; i++)
            if (hit < 0 && talker_addr_tab[i] == p.source_addr) hit = i;
         if (hit >= 0) begin
            if (talker_count_tab[hit] != 32'hFFFF_FFFF)
               talker_count_tab[hit] = talker_count_tab[hit] + 1;
         end else if (talkers_used < DEPTH) begin
            talker_addr_tab[talkers_used]  = p.source_addr;
            talker_count_tab[talkers_used] = 32'd1;
            talkers_used++;
         end else begin
            table_full_seen = 1'b1;
         end
      end
      if (window_pkts != 32'hFFFF_FFFF) window_pkts = window_pkts + 1;
      // Zero-extended, so a clock that runs backwards goes negative.
      elapsed = longint'({32'd0, p.time_sec}) - longint'({32'd0, open_sec});
      if (p.time_usec < open_usec) elapsed = elapsed - 1;
      if (elapsed >= longint'({52'd0, window_len})) rank_talkers(p.time_sec);
   endtask

   // Send one packet beat, idling first as the current phase asks.
   task automatic send_packet(input req_type p);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      count_packet(p);
      packets_sent++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      while (ranked_expect.size() != 0) @(posedge clock);
      // Packets that close nothing may still be walking the table.
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_window_len(input logic [11:0] secs);
      go_quiet();
      csr_write_en   <= 1'b1;
      csr_write_data <= secs;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      window_len = secs;
   endtask

   function automatic req_type make_packet(input logic [15:0] flen,
         input logic [15:0] etype, input logic [7:0] proto, input logic [31:0] addr,
         input logic [31:0] tsec, input logic [19:0] tusec);
      req_type p;
      p.frame_length = flen;
      p.ether_type   = etype;
      p.ip_protocol  = proto;
      p.source_addr  = addr;
      p.time_sec     = tsec;
      p.time_usec    = tusec;
      return p;
   endfunction

   // Field extremes, the qualification rules, the microsecond borrow, a clock
   // running backwards and an empty close, all under the reset window length.
   task automatic test_directed();
      send_packet(make_packet(16'd15, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0001, 32'd100, 20'd500000));
      send_packet(make_packet(16'hFFFF, ETHERTYPE_IPV4, PROTO_UDP, 32'h0A00_0002, 32'd100, 20'd600000));
      send_packet(make_packet(16'd60, ETHERTYPE_IPV4, PROTO_UDP, 32'h0A00_0002, 32'd100, 20'd700000));
      send_packet(make_packet(16'd14, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0003, 32'd100, 20'd800000));
      send_packet(make_packet(16'd0, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0003, 32'd100, 20'd800000));
      // Byte-swapped ethertype must not qualify.
      send_packet(make_packet(16'd64, 16'h0008, PROTO_TCP, 32'h0A00_0004, 32'd101, 20'd0));
      send_packet(make_packet(16'd64, 16'hFFFF, PROTO_TCP, 32'h0A00_0004, 32'd101, 20'd0));
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, 8'd0, 32'h0A00_0005, 32'd101, 20'd1));
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, 8'hFF, 32'h0A00_0005, 32'd101, 20'd2));
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, PROTO_TCP, 32'h0000_0000, 32'd101, 20'd999999));
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 32'd101, 20'd999999));
      // Two seconds apart but with a borrow: elapsed is still one.
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0001, 32'd102, 20'd400000));
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0001, 32'd99, 20'd0));
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, PROTO_TCP, 32'h0000_0000, 32'd102, 20'd500000));
      // A window with nothing counted closes with the empty marker.
      send_packet(make_packet(16'd10, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0009, 32'd200, 20'd0));
      send_packet(make_packet(16'd64, 16'h86DD, PROTO_TCP, 32'h0A00_0009, 32'd203, 20'd0));
   endtask

   // With a zero window every packet closes its own window.
   task automatic test_zero_window();
      write_window_len(12'd0);
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001,
                              32'hFFFF_FFFF, 20'd999999));
      send_packet(make_packet(16'd64, 16'h0806, PROTO_UDP, 32'hC0A8_0001, 32'd0, 20'd0));
      send_packet(make_packet(16'd64, ETHERTYPE_IPV4, PROTO_TCP, 32'hC0A8_0002, 32'd5, 20'd0));
   endtask

   // More distinct sources than table entries inside one long window.
   task automatic test_table_overflow();
      logic [31:0] base;
      base = $urandom;
      write_window_len(12'd3600);
      for (int i = 0; i < DEPTH + 4; i++)
         send_packet(make_packet(16'd100, ETHERTYPE_IPV4, (i % 2) ? PROTO_UDP : PROTO_TCP,
                                 base + i, 32'd5000, 20'd0));
      // Give six sources a higher count, all of them already in the table.
      for (int i = 0; i < 6; i++)
         send_packet(make_packet(16'd100, ETHERTYPE_IPV4, PROTO_TCP,
                                 base + 32'(i * 37), 32'd5000, 20'd1));
      send_packet(make_packet(16'd100, ETHERTYPE_IPV4, PROTO_TCP, base + DEPTH + 1,
                              32'd8600, 20'd0));
   endtask

   // Well-formed traffic from a small pool of sources, so counts collide and
   // ties are common, mixed with malformed and random packets.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [11:0] secs, input int count);
      logic [31:0] pool[12];
      logic [31:0] now_sec;
      logic [19:0] now_usec;
      int          r;
      int          us;
      req_type     p;
      write_window_len(secs);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      foreach (pool[i]) pool[i] = $urandom;
      now_sec  = $urandom;
      now_usec = 20'($urandom_range(999999));
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 60) begin
            us = int'(now_usec) + $urandom_range(400000);
            if (us > 999999) begin
               us = us - 1000000;
               now_sec = now_sec + 1;
            end
            now_usec = 20'(us);
         end else if (r < 85) begin
            now_sec = now_sec + 1;
         end else if (r < 96) begin
            now_sec  = now_sec + $urandom_range(2 * int'(secs) + 1);
            now_usec = 20'($urandom_range(999999));
         end else begin
            now_sec = now_sec - $urandom_range(5, 1);
         end
         if ($urandom_range(99) < 75) begin
            p = make_packet(16'($urandom_range(65535, 15)), ETHERTYPE_IPV4,
                            $urandom_range(1) ? PROTO_TCP : PROTO_UDP,
                            pool[$urandom_range(11)], now_sec, now_usec);
         end else begin
            p = make_packet(16'($urandom), 16'($urandom), 8'($urandom), $urandom,
                            now_sec, now_usec);
            case ($urandom_range(3))
               0: p.ether_type = 16'h0008;
               1: p.frame_length = MIN_FRAME_LEN;
               2: p.ether_type = ETHERTYPE_IPV4;
               default: ;
            endcase
         end
         send_packet(p);
      end
   endtask

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   // Every rsp beat must match the oldest predicted beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (ranked_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat: rank %0d addr %h count %0d",
                        rsp_payload.rank, rsp_payload.talker_addr, rsp_payload.talker_count);
         end else begin
            if (rsp_payload !== ranked_expect[0]) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("rsp mismatch, expected rank %0d addr %h count %0d pkts %0d",
                           ranked_expect[0].rank, ranked_expect[0].talker_addr,
                           ranked_expect[0].talker_count, ranked_expect[0].window_packets);
                  $display("   srcs %0d end %0d ovf %b valid %b last %b",
                           ranked_expect[0].distinct_sources, ranked_expect[0].window_end_sec,
                           ranked_expect[0].table_overflow, ranked_expect[0].entry_valid,
                           ranked_expect[0].last);
                  $display("   actual rank %0d addr %h count %0d pkts %0d",
                           rsp_payload.rank, rsp_payload.talker_addr,
                           rsp_payload.talker_count, rsp_payload.window_packets);
                  $display("   srcs %0d end %0d ovf %b valid %b last %b",
                           rsp_payload.distinct_sources, rsp_payload.window_end_sec,
                           rsp_payload.table_overflow, rsp_payload.entry_valid,
                           rsp_payload.last);
               end
            end
            void'(ranked_expect.pop_front());
         end
      end
   end

   // Watchdog: the run is hung if no beat moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      window_len = WINDOW_RESET;
      reset_window();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_zero_window();
      test_table_overflow();
      test_random_traffic(0, 0, 12'd1, 8);
      test_random_traffic(61, 0, 12'd3, 6);
      test_random_traffic(0, 61, 12'($urandom_range(4, 2)), 6);
      test_random_traffic(27, 27, 12'd4095, 4);
      test_random_traffic(27, 27, 12'd2, 4);

      go_quiet();
      $display("packets sent %0d, window closes %0d, ranked beats checked %0d",
               packets_sent, closes_seen, beats_checked);
      $display("mismatches %0d", mismatches);
      if (mismatches == 0 && ranked_expect.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ptt_pkg.sv
hdl/ptt_front.sv
hdl/ptt_fifo.sv
hdl/ptt_back.sv
hdl/per_source_window_top_talkers_top.sv
verif/tb_per_source_window_top_talkers_top.sv
